@@ rtl/core/dlpg_pkg.sv @@
`default_nettype none

package dlpg_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int COLOR_BITS = 8;

    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int NUM_BITS   = COORD_BITS + FRAC_BITS;
    localparam int SLOPE_BITS = FRAC_BITS + 2;
    localparam int PROD_BITS  = SLOPE_BITS + COORD_BITS;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 3;
    localparam int CNT_BITS   = $clog2(NUM_BITS);

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
        (ACC_BITS'(1) <<< FRAC_BITS) - ACC_BITS'(1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_WAIT,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic                  neg;
        logic [NUM_BITS-1:0]   num;
        logic [COORD_BITS-1:0] den;
    } div_req_t;

endpackage

`default_nettype wire

@@ rtl/core/dlpg_div.sv @@
`default_nettype none

module dlpg_div (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire dlpg_pkg::div_req_t                         req,
    output logic                                            done,
    output logic signed [dlpg_pkg::SLOPE_BITS-1:0]          quot
);

    logic                                  busy_reg, busy_next;
    logic                                  done_reg, done_next;
    logic [dlpg_pkg::CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic [dlpg_pkg::NUM_BITS-1:0]         quot_reg, quot_next;
    logic [dlpg_pkg::COORD_BITS-1:0]       rem_reg, rem_next;
    logic [dlpg_pkg::COORD_BITS-1:0]       den_reg, den_next;
    logic                                  neg_reg, neg_next;
    logic [dlpg_pkg::COORD_BITS:0]         trial;
    logic [dlpg_pkg::COORD_BITS:0]         diff;
    logic                                  fits;
    logic signed [dlpg_pkg::SLOPE_BITS-1:0] mag;

    assign trial = {rem_reg, quot_reg[dlpg_pkg::NUM_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};
    assign mag   = signed'(quot_reg[dlpg_pkg::SLOPE_BITS-1:0]);
    assign quot  = neg_reg ? -mag : mag;
    assign done  = done_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = req.num;
            rem_next  = '0;
            den_next  = req.den;
            neg_next  = req.neg;
        end
        else if (busy_reg)
        begin
            // restoring step: one quotient bit per cycle
            quot_next = {quot_reg[dlpg_pkg::NUM_BITS-2:0], fits};
            rem_next  = fits ? diff[dlpg_pkg::COORD_BITS-1:0]
                             : trial[dlpg_pkg::COORD_BITS-1:0];
            cnt_next  = cnt_reg + dlpg_pkg::CNT_BITS'(1);
            if (cnt_reg == dlpg_pkg::CNT_BITS'(dlpg_pkg::NUM_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/dlpg_mul.sv @@
`default_nettype none

module dlpg_mul (
    input  wire logic                                    clk,
    input  wire logic signed [dlpg_pkg::SLOPE_BITS-1:0]  a,
    input  wire logic signed [dlpg_pkg::COORD_BITS-1:0]  b,
    output logic signed [dlpg_pkg::PROD_BITS-1:0]        p
);

    logic signed [dlpg_pkg::PROD_BITS-1:0] p_reg, p_next;

    assign p_next = dlpg_pkg::PROD_BITS'(a) * dlpg_pkg::PROD_BITS'(b);
    assign p      = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/dda_line_pixel_generator.sv @@
// channel | handshake           | payload
// --------+---------------------+---------------------------------------------
// input   | in_valid, in_stall  | opcode, start_x/y, end_x/y, rgba _in
// output  | out_valid, out_stall| pixel_x, pixel_y, rgba _out, last_pixel
//
// Start transfer: the serial slope divider, then ST_MUL, ST_ADD and ST_EMIT run before
// the next transfer can be taken. Equal endpoints skip the divider.
// Step transfer: ST_MUL, ST_ADD and ST_EMIT through the shared multiplier and adder; a step
// with no line in progress is taken in ST_IDLE and gives no pixel.
// in_stall is high from acceptance until the pixel sits in the output register.
// Reset clears the sequencer, line state and output valid.
`default_nettype none

module dda_line_pixel_generator (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic                                    opcode,
    input  wire logic signed [dlpg_pkg::COORD_BITS-1:0]  start_x,
    input  wire logic signed [dlpg_pkg::COORD_BITS-1:0]  start_y,
    input  wire logic signed [dlpg_pkg::COORD_BITS-1:0]  end_x,
    input  wire logic signed [dlpg_pkg::COORD_BITS-1:0]  end_y,
    input  wire logic [dlpg_pkg::COLOR_BITS-1:0]         red_in,
    input  wire logic [dlpg_pkg::COLOR_BITS-1:0]         green_in,
    input  wire logic [dlpg_pkg::COLOR_BITS-1:0]         blue_in,
    input  wire logic [dlpg_pkg::COLOR_BITS-1:0]         alpha_in,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [dlpg_pkg::COORD_BITS-1:0]       pixel_x,
    output logic signed [dlpg_pkg::COORD_BITS-1:0]       pixel_y,
    output logic [dlpg_pkg::COLOR_BITS-1:0]              red_out,
    output logic [dlpg_pkg::COLOR_BITS-1:0]              green_out,
    output logic [dlpg_pkg::COLOR_BITS-1:0]              blue_out,
    output logic [dlpg_pkg::COLOR_BITS-1:0]              alpha_out,
    output logic                                         last_pixel
);

    localparam int C = dlpg_pkg::COORD_BITS;
    localparam int D = dlpg_pkg::DELTA_BITS;
    localparam int F = dlpg_pkg::FRAC_BITS;
    localparam int A = dlpg_pkg::ACC_BITS;
    localparam int S = dlpg_pkg::SLOPE_BITS;
    localparam int K = dlpg_pkg::COLOR_BITS;

    dlpg_pkg::state_t state_reg, state_next;

    logic                  line_active_reg, line_active_next;
    logic                  major_is_x_reg, major_is_x_next;
    logic                  step_neg_reg, step_neg_next;
    logic signed [C-1:0]   major_cur_reg, major_cur_next;
    logic signed [C-1:0]   major_final_reg, major_final_next;
    logic signed [C-1:0]   minor_start_reg, minor_start_next;
    logic signed [S-1:0]   slope_reg, slope_next;
    logic signed [A-1:0]   icpt_reg, icpt_next;
    logic [4*K-1:0]        colour_reg, colour_next;
    logic                  is_start_reg, is_start_next;
    logic signed [C-1:0]   pend_x_reg, pend_x_next;
    logic signed [C-1:0]   pend_y_reg, pend_y_next;
    logic                  pend_last_reg, pend_last_next;

    logic                  out_valid_reg, out_valid_next;
    logic signed [C-1:0]   out_x_reg, out_x_next;
    logic signed [C-1:0]   out_y_reg, out_y_next;
    logic [4*K-1:0]        out_colour_reg, out_colour_next;
    logic                  out_last_reg, out_last_next;

    logic                  in_xfer, out_xfer, out_free;
    logic signed [D-1:0]   dx, dy, adx, ady;
    logic [C-1:0]          adx_mag, ady_mag, dmaj_mag, dmin_mag;
    logic                  major_x, dmaj_neg, dmin_neg, dmaj_zero;
    logic signed [C-1:0]   major_step;

    logic signed [dlpg_pkg::PROD_BITS-1:0] prod;
    logic signed [A-1:0]   prod_ext, t_sum, t_adj, t_shift;
    logic signed [C-1:0]   minor_val;

    dlpg_pkg::div_req_t    div_req;
    logic                  div_done;
    logic signed [S-1:0]   div_quot;

    dlpg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    dlpg_mul u_mul (
        .clk (clk),
        .a   (slope_reg),
        .b   (major_cur_reg),
        .p   (prod)
    );

    assign in_stall = (state_reg != dlpg_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign dx       = D'(end_x) - D'(start_x);
    assign dy       = D'(end_y) - D'(start_y);
    assign adx      = dx[D-1] ? -dx : dx;
    assign ady      = dy[D-1] ? -dy : dy;
    assign adx_mag  = adx[C-1:0];
    assign ady_mag  = ady[C-1:0];
    assign major_x  = adx_mag > ady_mag;
    assign dmaj_mag = major_x ? adx_mag : ady_mag;
    assign dmin_mag = major_x ? ady_mag : adx_mag;
    assign dmaj_neg = major_x ? dx[D-1] : dy[D-1];
    assign dmin_neg = major_x ? dy[D-1] : dx[D-1];
    assign dmaj_zero = (dmaj_mag == '0);

    assign major_step = step_neg_reg ? major_cur_reg - C'(1) : major_cur_reg + C'(1);

    // minor = trunc((v + half) / 2^F) toward zero
    assign prod_ext  = A'(prod);
    assign t_sum     = prod_ext + icpt_reg + dlpg_pkg::ROUND_HALF;
    assign t_adj     = t_sum[A-1] ? t_sum + dlpg_pkg::ROUND_BIAS : t_sum;
    assign t_shift   = t_adj >>> F;
    assign minor_val = t_shift[C-1:0];

    assign div_req.start = in_xfer && (opcode == dlpg_pkg::OP_START) && !dmaj_zero;
    assign div_req.neg   = dmaj_neg ^ dmin_neg;
    assign div_req.num   = {dmin_mag, F'(0)};
    assign div_req.den   = dmaj_mag;

    always_comb
    begin
        state_next       = state_reg;
        line_active_next = line_active_reg;
        major_is_x_next  = major_is_x_reg;
        step_neg_next    = step_neg_reg;
        major_cur_next   = major_cur_reg;
        major_final_next = major_final_reg;
        minor_start_next = minor_start_reg;
        slope_next       = slope_reg;
        icpt_next        = icpt_reg;
        colour_next      = colour_reg;
        is_start_next    = is_start_reg;
        pend_x_next      = pend_x_reg;
        pend_y_next      = pend_y_reg;
        pend_last_next   = pend_last_reg;
        out_valid_next   = out_valid_reg && !out_xfer;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_colour_next  = out_colour_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            dlpg_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (opcode == dlpg_pkg::OP_START)
                    begin
                        colour_next      = {red_in, green_in, blue_in, alpha_in};
                        major_is_x_next  = major_x;
                        step_neg_next    = dmaj_neg;
                        major_cur_next   = major_x ? start_x : start_y;
                        major_final_next = major_x ? end_x : end_y;
                        minor_start_next = major_x ? start_y : start_x;
                        line_active_next = !dmaj_zero;
                        is_start_next    = 1'b1;
                        pend_x_next      = start_x;
                        pend_y_next      = start_y;
                        pend_last_next   = dmaj_zero;
                        if (dmaj_zero)
                        begin
                            slope_next = '0;
                            state_next = dlpg_pkg::ST_MUL;
                        end
                        else
                        begin
                            state_next = dlpg_pkg::ST_DIV_WAIT;
                        end
                    end
                    else if (line_active_reg)
                    begin
                        major_cur_next = major_step;
                        is_start_next  = 1'b0;
                        pend_last_next = (major_step == major_final_reg);
                        if (major_step == major_final_reg)
                        begin
                            line_active_next = 1'b0;
                        end
                        state_next = dlpg_pkg::ST_MUL;
                    end
                end
            end
            dlpg_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    slope_next = div_quot;
                    state_next = dlpg_pkg::ST_MUL;
                end
            end
            dlpg_pkg::ST_MUL:
            begin
                state_next = dlpg_pkg::ST_ADD;
            end
            dlpg_pkg::ST_ADD:
            begin
                if (is_start_reg)
                begin
                    icpt_next = (A'(minor_start_reg) <<< F) - prod_ext;
                end
                else
                begin
                    pend_x_next = major_is_x_reg ? major_cur_reg : minor_val;
                    pend_y_next = major_is_x_reg ? minor_val : major_cur_reg;
                end
                state_next = dlpg_pkg::ST_EMIT;
            end
            dlpg_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = pend_x_reg;
                    out_y_next      = pend_y_reg;
                    out_colour_next = colour_reg;
                    out_last_next   = pend_last_reg;
                    state_next      = dlpg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dlpg_pkg::ST_IDLE;
            line_active_reg <= 1'b0;
            major_is_x_reg  <= 1'b0;
            step_neg_reg    <= 1'b0;
            major_cur_reg   <= '0;
            major_final_reg <= '0;
            slope_reg       <= '0;
            icpt_reg        <= '0;
            colour_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            line_active_reg <= line_active_next;
            major_is_x_reg  <= major_is_x_next;
            step_neg_reg    <= step_neg_next;
            major_cur_reg   <= major_cur_next;
            major_final_reg <= major_final_next;
            slope_reg       <= slope_next;
            icpt_reg        <= icpt_next;
            colour_reg      <= colour_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        minor_start_reg <= minor_start_next;
        is_start_reg    <= is_start_next;
        pend_x_reg      <= pend_x_next;
        pend_y_reg      <= pend_y_next;
        pend_last_reg   <= pend_last_next;
        out_x_reg       <= out_x_next;
        out_y_reg       <= out_y_next;
        out_colour_reg  <= out_colour_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;
    assign red_out    = out_colour_reg[4*K-1:3*K];
    assign green_out  = out_colour_reg[3*K-1:2*K];
    assign blue_out   = out_colour_reg[2*K-1:K];
    assign alpha_out  = out_colour_reg[K-1:0];
    assign last_pixel = out_last_reg;

endmodule

`default_nettype wire
